@@ sv/csp_pkg.sv @@
`timescale 1ns / 1ps
package csp_pkg;

  localparam int QUEUE_DEPTH = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ACC_W       = SAMPLE_BITS + 4;
  localparam int ENTRY_W     = 2 * SAMPLE_BITS;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [3:0] RADIX     = 4'd10;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_POP   = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef struct packed {
    logic             pop_hit;
    logic             stored;
    logic             dropped;
    logic [CNT_W-1:0] fill;
  } meta_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

@@ sv/csv_sample_pair_parser_fifo_core.sv @@
`timescale 1ns / 1ps
// Decimal text parser feeding a ring FIFO of left/right sample pairs.
// Input channel (in_valid_i / in_stall_o): one beat carries kind_i and
// data_byte_i. Kinds: text byte, end of data, pop one pair, clear.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per
// input beat, in order: pop result (pair_valid_o, samples), push flags
// (pair_stored_o, pair_dropped_o) and fill_level_o after the beat.
// Throughput: one input beat per cycle unless the receiver stalls. Parser state,
// pointers and count sit in flops and are updated in the accept cycle; the pair
// store is a single-port-write, single-port-read RAM with a registered read.
// On acceptance the RAM read and the beat's flags load the RAM read stage;
// the output register loads from that stage when the output moves.
// A full 2048-entry queue drops completed pairs and flags them.
// Reset: parser idle, queue empty, both pipeline stages empty. The RAM is not
// cleared; only written entries are ever read. No clearing pass is needed.
// Receiver stall: the output register holds; one more beat is taken into the
// RAM read stage, after which in_stall_o rises until the output moves.
module csv_sample_pair_parser_fifo_core
  import csp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [7:0]             data_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   pair_valid_o,
  output logic [SAMPLE_BITS-1:0] left_sample_o,
  output logic [SAMPLE_BITS-1:0] right_sample_o,
  output logic                   pair_stored_o,
  output logic                   pair_dropped_o,
  output logic [CNT_W-1:0]       fill_level_o
);

  logic [SAMPLE_BITS-1:0] acc_q, acc_d;
  logic                   digit_q, digit_d;
  logic                   right_q, right_d;
  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [PTR_W-1:0]       rp_q, rp_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   p1_valid_q;
  meta_t                  p1_meta_q, meta_d;
  logic                   p1_move;
  logic                   accept;

  logic                   out_valid_q;
  logic                   out_pv_q, out_st_q, out_dr_q;
  logic [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic [CNT_W-1:0]       out_fill_q;

  logic                   we, re;
  logic [ENTRY_W-1:0]     wdata, rdata;
  logic [ACC_W-1:0]       prod;
  logic [7:0]             digit_off;
  kind_e                  kind;

  assign p1_move    = p1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p1_valid_q && !p1_move;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic             push;
    logic [SAMPLE_BITS-1:0] pl, pr;
    kind      = kind_e'(kind_i);
    digit_off = data_byte_i - CHAR_ZERO;
    prod      = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
              + ACC_W'(digit_off[3:0]);
    push      = 1'b0;
    pl        = held_q;
    pr        = acc_q;
    acc_d     = acc_q;
    digit_d   = digit_q;
    right_d   = right_q;
    held_d    = held_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    re        = 1'b0;
    meta_d    = '0;
    case (kind)
      KIND_BYTE: begin
        if (data_byte_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
          acc_d   = (prod[ACC_W-1:SAMPLE_BITS] != '0) ? '1 : prod[SAMPLE_BITS-1:0];
          digit_d = 1'b1;
        end else begin
          acc_d   = '0;
          digit_d = 1'b0;
          if (!right_q) begin
            held_d  = acc_q;
            right_d = 1'b1;
          end else begin
            push    = 1'b1;
            right_d = 1'b0;
            held_d  = '0;
          end
        end
      end
      KIND_END: begin
        push    = digit_q && right_q;
        acc_d   = '0;
        digit_d = 1'b0;
        right_d = 1'b0;
        held_d  = '0;
      end
      KIND_POP: begin
        if (cnt_q != '0) begin
          re             = 1'b1;
          meta_d.pop_hit = 1'b1;
          rp_d           = ptr_next(rp_q);
          cnt_d          = cnt_q - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        acc_d   = '0;
        digit_d = 1'b0;
        right_d = 1'b0;
        held_d  = '0;
        wp_d    = '0;
        rp_d    = '0;
        cnt_d   = '0;
      end
      default: begin
      end
    endcase
    we = 1'b0;
    if (push) begin
      if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
        meta_d.dropped = 1'b1;
      end else begin
        we            = 1'b1;
        meta_d.stored = 1'b1;
        wp_d          = ptr_next(wp_q);
        cnt_d         = cnt_q + CNT_W'(1);
      end
    end
    wdata       = {pl, pr};
    meta_d.fill = cnt_d;
    we          = we && accept;
    re          = re && accept;
  end

  csp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      digit_q     <= 1'b0;
      right_q     <= 1'b0;
      held_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q   <= acc_d;
        digit_q <= digit_d;
        right_q <= right_d;
        held_q  <= held_d;
        wp_q    <= wp_d;
        rp_q    <= rp_d;
        cnt_q   <= cnt_d;
      end
      if (accept) begin
        p1_valid_q <= 1'b1;
      end else if (p1_move) begin
        p1_valid_q <= 1'b0;
      end
      if (p1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_meta_q <= meta_d;
    end
    if (p1_move) begin
      out_pv_q    <= p1_meta_q.pop_hit;
      out_left_q  <= p1_meta_q.pop_hit ? rdata[ENTRY_W-1:SAMPLE_BITS] : '0;
      out_right_q <= p1_meta_q.pop_hit ? rdata[SAMPLE_BITS-1:0] : '0;
      out_st_q    <= p1_meta_q.stored;
      out_dr_q    <= p1_meta_q.dropped;
      out_fill_q  <= p1_meta_q.fill;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pair_valid_o   = out_pv_q;
  assign left_sample_o  = out_left_q;
  assign right_sample_o = out_right_q;
  assign pair_stored_o  = out_st_q;
  assign pair_dropped_o = out_dr_q;
  assign fill_level_o   = out_fill_q;

endmodule

@@ sv/csp_ram.sv @@
`timescale 1ns / 1ps
module csp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
